### rtl/dtq_pkg.sv
// Package for the decimal text to Q7.8 parser: item types, character codes, power-of-ten table.
package dtq_pkg;

  localparam int MAX_FRAC_DIGITS_DEF = 8;
  // Fraction bits of Q7.8; also the number of quotient bits the divider produces.
  localparam int FRAC_BITS = 8;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [15:0] fixed_value;
    logic               status;
  } out_t;

  // 10^n for n = 0..9.
  function automatic logic [33:0] pow10_f(input logic [3:0] n);
    logic [33:0] p;
    case (n)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd1;
    endcase
    return p;
  endfunction

endpackage

### rtl/decimal_text_to_q7_8.sv
// Streaming parser from ASCII decimal text to a Q7.8 fixed-point value.
// Throughput: one character item per cycle while a number is being parsed.
// After the last character is accepted, the bit-serial restoring divider runs
//   (one quotient bit per cycle, 8 bits); the result is then registered once the output can take it.
// Input is held off until the result is registered; the result register frees the next number.
// Reset (async, active low) clears the parser, the divider step count and the result valid.
module decimal_text_to_q7_8
  import dtq_pkg::*;
#(
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam logic [33:0] MaxPow = pow10_f(4'(MAX_FRAC_DIGITS));
  localparam int FW  = $clog2(MaxPow);
  localparam int FXW = FW + 4;
  localparam int CW  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int SW  = $clog2(FRAC_BITS + 1);

  typedef enum logic [1:0] {PH_START, PH_INT, PH_FRAC, PH_DONE} phase_e;
  typedef enum logic {ST_PARSE, ST_DIV} state_e;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [7:0]      int_q, int_d;
  logic            ovf_q, ovf_d;
  logic [FW-1:0]   frac_q, frac_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [FW-1:0]   rem_q, rem_d;
  logic [FW-1:0]   divisor_q, divisor_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;
  logic [SW-1:0]   steps_q, steps_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic            take;
  logic [3:0]      digit;
  logic            is_digit;
  logic [11:0]     int_x;
  logic [FXW-1:0]  frac_x;
  logic [FW:0]     rem2;
  logic            fits;
  logic            bad;
  logic [15:0]     mag;

  assign in_ready_o  = (state_q == ST_PARSE);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign digit    = 4'(in_i.char_code - CHAR_ZERO);
  assign is_digit = (in_i.char_code >= CHAR_ZERO) && (in_i.char_code <= CHAR_NINE);
  assign int_x    = 12'(int_q) * 12'd10 + 12'(digit);
  assign frac_x   = FXW'(frac_q) * FXW'(10) + FXW'(digit);

  // restoring division step: remainder stays below the divisor
  assign rem2 = {rem_q, 1'b0};
  assign fits = rem2 >= {1'b0, divisor_q};

  always_comb begin
    bad = ovf_q;
    if (neg_q) begin
      if (int_q > 8'd128) begin
        bad = 1'b1;
      end else if (int_q == 8'd128 && quo_q != '0) begin
        bad = 1'b1;
      end
    end else if (int_q > 8'd127) begin
      bad = 1'b1;
    end
    mag = {int_q, quo_q};
  end

  always_comb begin
    logic skip;
    skip        = 1'b0;
    state_d     = state_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    int_d       = int_q;
    ovf_d       = ovf_q;
    frac_d      = frac_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    divisor_d   = divisor_q;
    quo_d       = quo_q;
    steps_d     = steps_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_PARSE: begin
        if (take) begin
          if (phase_d == PH_START) begin
            phase_d = PH_INT;
            if (in_i.char_code == CHAR_MINUS) begin
              neg_d = 1'b1;
              skip  = 1'b1;
            end
          end
          if (!skip) begin
            if (phase_d == PH_INT) begin
              if (is_digit) begin
                if (int_x > 12'd255) begin
                  ovf_d = 1'b1;
                end else begin
                  int_d = int_x[7:0];
                end
              end else if (in_i.char_code == CHAR_DOT || in_i.char_code == CHAR_COMMA) begin
                phase_d = PH_FRAC;
              end else begin
                phase_d = PH_DONE;
              end
            end else if (phase_d == PH_FRAC) begin
              if (is_digit) begin
                if (cnt_q < CW'(MAX_FRAC_DIGITS)) begin
                  frac_d = frac_x[FW-1:0];
                  cnt_d  = cnt_q + 1'b1;
                end
              end else begin
                phase_d = PH_DONE;
              end
            end
          end
          if (in_i.last_char) begin
            state_d   = ST_DIV;
            rem_d     = frac_d;
            divisor_d = FW'(pow10_f(4'(cnt_d)));
            quo_d     = '0;
            steps_d   = SW'(FRAC_BITS);
          end
        end
      end
      ST_DIV: begin
        if (steps_q != '0) begin
          rem_d   = fits ? FW'(rem2 - {1'b0, divisor_q}) : rem2[FW-1:0];
          quo_d   = {quo_q[FRAC_BITS-2:0], fits};
          steps_d = steps_q - 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (bad) begin
            out_d.fixed_value = '0;
            out_d.status      = 1'b1;
          end else begin
            out_d.fixed_value = neg_q ? (~mag + 16'd1) : mag;
            out_d.status      = 1'b0;
          end
          state_d = ST_PARSE;
          phase_d = PH_START;
          neg_d   = 1'b0;
          int_d   = '0;
          ovf_d   = 1'b0;
          frac_d  = '0;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = ST_PARSE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      phase_q     <= PH_START;
      neg_q       <= 1'b0;
      int_q       <= '0;
      ovf_q       <= 1'b0;
      frac_q      <= '0;
      cnt_q       <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      int_q       <= int_d;
      ovf_q       <= ovf_d;
      frac_q      <= frac_d;
      cnt_q       <= cnt_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    quo_q     <= quo_d;
    out_q     <= out_d;
  end

endmodule

### tb/sv/dtq_result_checker.sv
`timescale 1ns / 100ps
// Checker for decimal_text_to_q7_8: follows accepted characters, predicts each Q7.8 result, compares.
module dtq_result_checker
  import dtq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   mismatch_count_o,
  output int   pending_o
);

  typedef enum logic [1:0] {SCAN_START, SCAN_INT, SCAN_FRAC, SCAN_DONE} scan_e;

  scan_e       scan_q;
  logic        neg_q;
  logic [7:0]  int_acc_q;
  logic        int_ovf_q;
  logic [26:0] frac_acc_q;
  logic [3:0]  frac_cnt_q;

  out_t q78_expected[$];
  int   mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic logic is_digit_f(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function void clear_scan();
    scan_q     = SCAN_START;
    neg_q      = 1'b0;
    int_acc_q  = '0;
    int_ovf_q  = 1'b0;
    frac_acc_q = '0;
    frac_cnt_q = '0;
  endfunction

  function void absorb_char(input logic [7:0] c);
    int unsigned next_int;
    if (scan_q == SCAN_START) begin
      scan_q = SCAN_INT;
      if (c == CHAR_MINUS) begin
        neg_q = 1'b1;
        return;
      end
    end
    if (scan_q == SCAN_INT) begin
      if (is_digit_f(c)) begin
        next_int = 32'(int_acc_q) * 10 + 32'(c - CHAR_ZERO);
        // overflow is sticky and the accumulator keeps its last good value
        if (next_int > 255) int_ovf_q = 1'b1;
        else int_acc_q = next_int[7:0];
      end else if (c == CHAR_DOT || c == CHAR_COMMA) begin
        scan_q = SCAN_FRAC;
      end else begin
        scan_q = SCAN_DONE;
      end
    end else if (scan_q == SCAN_FRAC) begin
      if (is_digit_f(c)) begin
        if (frac_cnt_q < MAX_FRAC_DIGITS_DEF) begin
          frac_acc_q = frac_acc_q * 10 + 27'(c - CHAR_ZERO);
          frac_cnt_q = frac_cnt_q + 1;
        end
      end else begin
        scan_q = SCAN_DONE;
      end
    end
  endfunction

  function out_t q78_of_scan();
    longint unsigned divisor;
    longint unsigned scaled;
    logic            bad;
    logic [15:0]     mag;
    out_t            r;
    int              k;
    scaled = 0;
    if (frac_cnt_q != 0) begin
      divisor = 1;
      for (k = 0; k < frac_cnt_q; k++) divisor = divisor * 10;
      scaled = frac_acc_q;
      scaled = (scaled << 8) / divisor;
    end
    bad = int_ovf_q;
    if (neg_q) begin
      if (int_acc_q > 128) bad = 1'b1;
      else if (int_acc_q == 128 && scaled != 0) bad = 1'b1;
    end else if (int_acc_q > 127) begin
      bad = 1'b1;
    end
    if (bad) begin
      r.fixed_value = '0;
      r.status      = 1'b1;
    end else begin
      mag = {int_acc_q, 8'h00} + scaled[15:0];
      if (neg_q) mag = -mag;
      r.fixed_value = mag;
      r.status      = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      clear_scan();
      q78_expected.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (q78_expected.size() == 0) begin
          $error("result with none expected: fixed_value %0d status %0b",
                 $signed(out_i.fixed_value), out_i.status);
          mismatches++;
        end else begin
          want = q78_expected.pop_front();
          if (out_i.fixed_value !== want.fixed_value) begin
            $error("fixed_value: expected %0d, actual %0d",
                   $signed(want.fixed_value), $signed(out_i.fixed_value));
            mismatches++;
          end
          if (out_i.status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, out_i.status);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        absorb_char(in_i.char_code);
        if (in_i.last_char) begin
          q78_expected.push_back(q78_of_scan());
          clear_scan();
        end
      end
      pending_o <= q78_expected.size();
    end
  end

endmodule

### tb/sv/decimal_text_to_q7_8_tb.sv
`timescale 1ns / 100ps
// Testbench top for decimal_text_to_q7_8: number text stimulus, ready pacing and the verdict.
module decimal_text_to_q7_8_tb
  import dtq_pkg::*;
;

  logic clk_i;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic steady    = 1'b0;  // no idling on either side while set

  int mismatches;
  int results_due;
  int chars_sent  = 0;

  logic [7:0] text_q[$];

  decimal_text_to_q7_8 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  dtq_result_checker q78_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_i             (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_i            (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("decimal_text_to_q7_8 test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready <= steady || ($urandom_range(99) >= 27);
  end

  function void put_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function void put_digits(input int n);
    repeat (n) text_q.push_back(8'(CHAR_ZERO + $urandom_range(9)));
  endfunction

  // Mostly well-formed numbers with random content; some raw byte noise.
  function void build_random_text();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(1)) text_q.push_back(CHAR_MINUS);
      case ($urandom_range(7))
        0: ;
        1: put_str($urandom_range(1) ? "128" : "127");
        2: put_digits($urandom_range(1, 4));
        3: begin
          put_str("00");
          put_digits(1);
        end
        default: put_str($sformatf("%0d", $urandom_range(140)));
      endcase
      if ($urandom_range(99) < 70) begin
        text_q.push_back($urandom_range(1) ? CHAR_DOT : CHAR_COMMA);
        put_digits($urandom_range(10));
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_item(input in_t item);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic send_text();
    in_t item;
    int  i;
    for (i = 0; i < text_q.size(); i++) begin
      item.char_code = text_q[i];
      item.last_char = (i == text_q.size() - 1);
      send_item(item);
    end
    chars_sent += text_q.size();
    text_q.delete();
  endtask

  initial begin
    string directed[16] = '{"0", "-128", "-128.0", "-128.5", "127.99609375", "128",
                            "-129", "1000", "1,5", "0.123456789", "-", ".", "--5",
                            "12a9", "-0", "-0.00000001"};
    int random_start;
    int numbers;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      put_str(directed[i]);
      send_text();
    end
    // control bytes with every bit low and every bit high
    put_str("7");
    text_q.push_back(8'h00);
    send_text();
    text_q.push_back(8'hFF);
    send_text();

    random_start = chars_sent;
    numbers = 0;
    while (chars_sent - random_start < 500) begin
      steady <= (numbers >= 60 && numbers < 100);
      if (numbers == 40) begin
        // hold off until the block has delivered everything owed
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (results_due != 0) @(posedge clk_i);
      end
      build_random_text();
      send_text();
      numbers++;
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("decimal_text_to_q7_8 test passed");
    end else begin
      $display("decimal_text_to_q7_8 test failed");
    end
    $finish;
  end

endmodule
